/* design/stepper_half_step_homing_sequencer_unit_macros.svh */
// assertion helpers for the half-step sequencer
`ifndef STEPPER_HALF_STEP_HOMING_SEQUENCER_UNIT_MACROS_SVH
`define STEPPER_HALF_STEP_HOMING_SEQUENCER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define HSS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hss check failed");

// next-cycle implication, sampled on clk, quiet during reset
`define HSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hss check failed");

`endif

/* design/hss_pkg.sv */
package hss_pkg;

  localparam int COUNT_WIDTH = 16;
  typedef logic [COUNT_WIDTH-1:0] count_t;
  localparam logic [31:0] COUNT_MAX32 = 32'((64'd1 << COUNT_WIDTH) - 64'd1);

  // command codes
  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_REVERSE = 2'd1;
  localparam logic [1:0] CMD_SEARCH  = 2'd2;

  // run modes
  localparam logic [1:0] MODE_IDLE    = 2'd0;
  localparam logic [1:0] MODE_REVERSE = 2'd1;
  localparam logic [1:0] MODE_SEARCH  = 2'd2;
  localparam logic [1:0] MODE_OVERRUN = 2'd3;

  // register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERRUN      = 1'b1;

  localparam logic [15:0] SEARCH_LIMIT_RST = 16'd500;
  localparam logic [3:0]  OVERRUN_RST      = 4'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] step_count;
    logic        home_sensor;
  } item_t;

  typedef struct packed {
    logic [3:0] coil_pattern;
    logic       stepped;
    logic       busy_res;
    logic       finished;
  } result_t;

  typedef struct packed {
    logic [15:0] search_limit;
    logic [3:0]  overrun_steps;
  } cfg_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       count_zero;
  } status_t;

  function automatic logic [3:0] fwd_coils(input logic [2:0] p);
    logic [3:0] c;
    unique case (p)
      3'd0: c = 4'h9;
      3'd1: c = 4'h1;
      3'd2: c = 4'h3;
      3'd3: c = 4'h2;
      3'd4: c = 4'h6;
      3'd5: c = 4'h4;
      3'd6: c = 4'hc;
      default: c = 4'h8;
    endcase
    return c;
  endfunction

  function automatic logic [3:0] rev_coils(input logic [2:0] p);
    logic [3:0] c;
    unique case (p)
      3'd0: c = 4'h8;
      3'd1: c = 4'hc;
      3'd2: c = 4'h4;
      3'd3: c = 4'h6;
      3'd4: c = 4'h2;
      3'd5: c = 4'h3;
      3'd6: c = 4'h1;
      default: c = 4'h9;
    endcase
    return c;
  endfunction

  // clamp a 16-bit count into the counter width
  function automatic count_t sat_count(input logic [15:0] v);
    logic [31:0] w;
    w = 32'(v);
    if (w > COUNT_MAX32) begin
      w = COUNT_MAX32;
    end
    return COUNT_WIDTH'(w);
  endfunction

endpackage

/* design/hss_if.sv */
interface hss_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] step_count;
  logic        home_sensor;
  modport source (output valid, cmd, step_count, home_sensor, input ready);
  modport sink (input valid, cmd, step_count, home_sensor, output ready);
endinterface

interface hss_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] coil_pattern;
  logic       stepped;
  logic       busy_res;
  logic       finished;
  modport source (output valid, coil_pattern, stepped, busy_res, finished, input ready);
  modport sink (input valid, coil_pattern, stepped, busy_res, finished, output ready);
endinterface

interface hss_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [hss_pkg::CFG_IDX_W-1:0]  index;
  logic [15:0]                    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* design/hss_cfg_regs.sv */
module hss_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [hss_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [15:0]                   wr_data,
  output hss_pkg::cfg_t                 cfg
);

  logic [15:0] search_limit_r;
  logic [3:0]  overrun_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      search_limit_r <= hss_pkg::SEARCH_LIMIT_RST;
      overrun_r      <= hss_pkg::OVERRUN_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        hss_pkg::CFG_SEARCH_LIMIT: search_limit_r <= wr_data;
        hss_pkg::CFG_OVERRUN:      overrun_r      <= wr_data[3:0];
        default: ;
      endcase
    end
  end

  assign cfg.search_limit  = search_limit_r;
  assign cfg.overrun_steps = overrun_r;

endmodule

/* design/hss_step.sv */
module hss_step (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  hss_pkg::item_t   item,
  input  hss_pkg::cfg_t    cfg,
  output hss_pkg::result_t result,
  output hss_pkg::status_t status
);

  logic [2:0]      phase_r, phase_nxt;
  logic [1:0]      mode_r, mode_nxt;
  hss_pkg::count_t count_r, count_nxt;
  logic [3:0]      coil_r, coil_nxt;
  logic            stepped, finished;
  hss_pkg::count_t count_dec, count_inc, limit;

  assign count_dec = count_r - hss_pkg::count_t'(1);
  assign count_inc = count_r + hss_pkg::count_t'(1);
  // zero limit behaves as one
  assign limit = hss_pkg::sat_count((cfg.search_limit == 16'd0) ? 16'd1 : cfg.search_limit);

  always_comb begin
    phase_nxt = phase_r;
    mode_nxt  = mode_r;
    count_nxt = count_r;
    coil_nxt  = coil_r;
    stepped   = 1'b0;
    finished  = 1'b0;
    unique case (item.cmd)
      hss_pkg::CMD_REVERSE: begin
        if (mode_r == hss_pkg::MODE_IDLE) begin
          if (item.step_count == 16'd0) begin
            finished = 1'b1;
          end else begin
            mode_nxt  = hss_pkg::MODE_REVERSE;
            count_nxt = hss_pkg::sat_count(item.step_count);
          end
        end
      end
      hss_pkg::CMD_SEARCH: begin
        if (mode_r == hss_pkg::MODE_IDLE) begin
          mode_nxt  = hss_pkg::MODE_SEARCH;
          count_nxt = '0;
        end
      end
      hss_pkg::CMD_TICK: begin
        unique case (mode_r)
          hss_pkg::MODE_REVERSE: begin
            coil_nxt  = hss_pkg::rev_coils(phase_r);
            phase_nxt = phase_r + 3'd1;
            stepped   = 1'b1;
            count_nxt = count_dec;
            if (count_dec == '0) begin
              mode_nxt = hss_pkg::MODE_IDLE;
              finished = 1'b1;
            end
          end
          hss_pkg::MODE_SEARCH: begin
            coil_nxt  = hss_pkg::fwd_coils(phase_r);
            phase_nxt = phase_r + 3'd1;
            stepped   = 1'b1;
            count_nxt = count_inc;
            if (item.home_sensor || (count_inc >= limit)) begin
              if (cfg.overrun_steps == 4'd0) begin
                mode_nxt  = hss_pkg::MODE_IDLE;
                count_nxt = '0;
                finished  = 1'b1;
              end else begin
                mode_nxt  = hss_pkg::MODE_OVERRUN;
                count_nxt = hss_pkg::COUNT_WIDTH'(cfg.overrun_steps);
              end
            end
          end
          hss_pkg::MODE_OVERRUN: begin
            coil_nxt  = hss_pkg::fwd_coils(phase_r);
            phase_nxt = phase_r + 3'd1;
            stepped   = 1'b1;
            count_nxt = count_dec;
            if (count_dec == '0) begin
              mode_nxt = hss_pkg::MODE_IDLE;
              finished = 1'b1;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      mode_r  <= hss_pkg::MODE_IDLE;
      count_r <= '0;
      coil_r  <= '0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      mode_r  <= mode_nxt;
      count_r <= count_nxt;
      coil_r  <= coil_nxt;
    end
  end

  assign result.coil_pattern = coil_nxt;
  assign result.stepped      = stepped;
  assign result.busy_res     = (mode_nxt != hss_pkg::MODE_IDLE);
  assign result.finished     = finished;

  assign status.mode       = mode_r;
  assign status.count_zero = (count_r == '0);

endmodule

/* design/stepper_half_step_homing_sequencer_unit.sv */
// a beat accepted into the input register passes through the step logic into the result
// register, from which it is offered to the sink
// throughput: one beat per cycle while the sink keeps ready high; the step logic between the
// two registers is one table lookup, a counter add and a compare
// reset: synchronous active-low; phase 0, idle, coils off, search_limit 500, overrun 3,
// both pipeline registers empty
`include "stepper_half_step_homing_sequencer_unit_macros.svh"

module stepper_half_step_homing_sequencer_unit (
  input  logic      clk,
  input  logic      rst_n,
  hss_in_if.sink    in_ch,
  hss_out_if.source out_ch,
  hss_cfg_if.sink   cfg_ch
);

  // input register: holds one command beat until the step logic takes it
  logic             in_v_r;
  hss_pkg::item_t   in_item_r;
  // result register: holds one result beat until the sink takes it
  logic             out_v_r;
  hss_pkg::result_t out_data_r;

  logic             advance;
  logic             out_free;
  hss_pkg::item_t   in_item;
  hss_pkg::result_t step_result;
  hss_pkg::status_t step_status;
  hss_pkg::cfg_t    cfg;

  // the result slot frees when it is empty or being drained this cycle
  assign out_free = !out_v_r || out_ch.ready;
  // the held beat moves through the step logic into the result slot
  assign advance  = in_v_r && out_free;
  // the input slot takes a new beat when empty or emptying now
  assign in_ch.ready = !in_v_r || advance;

  assign in_item.cmd         = in_ch.cmd;
  assign in_item.step_count  = in_ch.step_count;
  assign in_item.home_sensor = in_ch.home_sensor;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_item_r <= in_item;
    end
  end

  // config writes are always taken
  assign cfg_ch.ready = 1'b1;

  hss_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  // phase, mode, counter and coil state advance once per processed beat
  hss_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (in_item_r),
    .cfg     (cfg),
    .result  (step_result),
    .status  (step_status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= step_result;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.coil_pattern = out_data_r.coil_pattern;
  assign out_ch.stepped      = out_data_r.stepped;
  assign out_ch.busy_res     = out_data_r.busy_res;
  assign out_ch.finished     = out_data_r.finished;

  // a completing beat never reports busy
  `HSS_ASSERT_SAME(a_finish_not_busy, out_v_r && out_data_r.finished, !out_data_r.busy_res)
  // a step only happens while a run is active or on its completing beat
  `HSS_ASSERT_SAME(a_step_in_run, out_v_r && out_data_r.stepped,
                   out_data_r.busy_res || out_data_r.finished)
  // idle always leaves the step counter cleared
  `HSS_ASSERT_SAME(a_idle_count_zero, step_status.mode == hss_pkg::MODE_IDLE,
                   step_status.count_zero)
  // a held beat that cannot move blocks the input side
  `HSS_ASSERT_SAME(a_full_blocks_input, in_v_r && !out_free, !in_ch.ready)
  // a processed beat always lands in the result slot
  `HSS_ASSERT_NEXT(a_advance_fills_out, advance, out_v_r)

endmodule

/* verif/stepper_half_step_homing_sequencer_unit_checker.sv */
`timescale 1ns / 100ps

module stepper_half_step_homing_sequencer_unit_checker (
  input  logic clk,
  input  logic rst_n,
  hss_in_if    in_ch,
  hss_out_if   out_ch,
  hss_cfg_if   cfg_ch,
  output int   error_count,
  output int   results_owed,
  output logic motor_running
);

  // half-step coil tables, nibble p holds the pattern for phase p
  localparam logic [31:0] FWD_COILS = 32'h8c462319;
  localparam logic [31:0] REV_COILS = 32'h913264c8;

  logic [15:0]      search_limit;
  logic [3:0]       overrun_steps;
  logic [2:0]       phase_pos;
  logic [1:0]       run_mode;
  hss_pkg::count_t  steps_left;
  logic [3:0]       coils;
  hss_pkg::result_t pending_drive_q[$];
  int               mismatches = 0;
  int               beat_no = 0;

  function hss_pkg::count_t clamp_count(input logic [15:0] v);
    if (32'(v) > hss_pkg::COUNT_MAX32) begin
      return hss_pkg::count_t'(hss_pkg::COUNT_MAX32);
    end
    return hss_pkg::count_t'(v);
  endfunction

  function void half_step(input logic forward);
    if (forward) begin
      coils = FWD_COILS[{phase_pos, 2'b00} +: 4];
    end else begin
      coils = REV_COILS[{phase_pos, 2'b00} +: 4];
    end
    phase_pos = phase_pos + 3'd1;
  endfunction

  function hss_pkg::result_t advance_sequencer(input logic [1:0] cmd,
                                               input logic [15:0] count,
                                               input logic sensor);
    hss_pkg::result_t r;
    logic [15:0]      lim;
    r = '0;
    case (cmd)
      hss_pkg::CMD_REVERSE: begin
        if (run_mode == hss_pkg::MODE_IDLE) begin
          if (count == 16'd0) begin
            r.finished = 1'b1;
          end else begin
            run_mode   = hss_pkg::MODE_REVERSE;
            steps_left = clamp_count(count);
          end
        end
      end
      hss_pkg::CMD_SEARCH: begin
        if (run_mode == hss_pkg::MODE_IDLE) begin
          run_mode   = hss_pkg::MODE_SEARCH;
          steps_left = '0;
        end
      end
      hss_pkg::CMD_TICK: begin
        if (run_mode != hss_pkg::MODE_IDLE) begin
          half_step(run_mode != hss_pkg::MODE_REVERSE);
          r.stepped = 1'b1;
        end
        case (run_mode)
          hss_pkg::MODE_REVERSE, hss_pkg::MODE_OVERRUN: begin
            steps_left = steps_left - hss_pkg::count_t'(1);
            if (steps_left == '0) begin
              run_mode   = hss_pkg::MODE_IDLE;
              r.finished = 1'b1;
            end
          end
          hss_pkg::MODE_SEARCH: begin
            lim        = (search_limit == 16'd0) ? 16'd1 : search_limit;
            steps_left = steps_left + hss_pkg::count_t'(1);
            if (sensor || 32'(steps_left) >= 32'(clamp_count(lim))) begin
              if (overrun_steps == 4'd0) begin
                run_mode   = hss_pkg::MODE_IDLE;
                steps_left = '0;
                r.finished = 1'b1;
              end else begin
                run_mode   = hss_pkg::MODE_OVERRUN;
                steps_left = hss_pkg::count_t'(overrun_steps);
              end
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    r.coil_pattern = coils;
    r.busy_res     = (run_mode != hss_pkg::MODE_IDLE);
    return r;
  endfunction

  always @(posedge clk) begin
    hss_pkg::result_t got;
    hss_pkg::result_t want;
    if (!rst_n) begin
      search_limit  = hss_pkg::SEARCH_LIMIT_RST;
      overrun_steps = hss_pkg::OVERRUN_RST;
      phase_pos     = '0;
      run_mode      = hss_pkg::MODE_IDLE;
      steps_left    = '0;
      coils         = '0;
      pending_drive_q.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          hss_pkg::CFG_SEARCH_LIMIT: search_limit = cfg_ch.data;
          hss_pkg::CFG_OVERRUN:      overrun_steps = cfg_ch.data[3:0];
          default: ;
        endcase
      end
      // results pass the input and result registers before they leave, so retire before predicting
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.coil_pattern, out_ch.stepped, out_ch.busy_res, out_ch.finished};
        beat_no++;
        if (pending_drive_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result beat %0d with nothing outstanding: coils %h step %b busy %b done %b",
                     beat_no, got.coil_pattern, got.stepped, got.busy_res, got.finished);
          end
        end else begin
          want = pending_drive_q.pop_front();
          if (got.coil_pattern !== want.coil_pattern || got.stepped !== want.stepped ||
              got.busy_res !== want.busy_res || got.finished !== want.finished) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result beat %0d: expected coils %h step %b busy %b done %b",
                       beat_no, want.coil_pattern, want.stepped, want.busy_res,
                       want.finished);
              $display("  got coils %h step %b busy %b done %b",
                       got.coil_pattern, got.stepped, got.busy_res, got.finished);
            end
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        pending_drive_q.push_back(advance_sequencer(in_ch.cmd, in_ch.step_count,
                                                    in_ch.home_sensor));
      end
    end
    error_count   <= mismatches;
    results_owed  <= pending_drive_q.size();
    motor_running <= (run_mode != hss_pkg::MODE_IDLE);
  end

endmodule

/* verif/stepper_half_step_homing_sequencer_unit_test.sv */
`timescale 1ns / 100ps

module stepper_half_step_homing_sequencer_unit_test;

  // the one command code the block treats as nothing at all
  localparam logic [1:0] CMD_IGNORED = 2'd3;
  localparam int PHASE_ITEMS  = 270;
  // two pipeline registers plus margin
  localparam int DRAIN_CYCLES = 6;

  logic       clk;
  logic       rst_n;
  int         error_count;
  int         results_owed;
  logic       motor_running;
  bit         steady = 1'b0;   // set: neither side inserts gaps
  logic [3:0] overrun_now = hss_pkg::OVERRUN_RST;
  int         items_sent = 0;

  hss_in_if  in_ch();
  hss_out_if out_ch();
  hss_cfg_if cfg_ch();

  stepper_half_step_homing_sequencer_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  stepper_half_step_homing_sequencer_unit_checker sequencer_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_ch        (cfg_ch),
    .error_count   (error_count),
    .results_owed  (results_owed),
    .motor_running (motor_running)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop well past the slowest legal run
  initial begin
    #4000000;
    $display("FAIL stepper_half_step_homing_sequencer_unit");
    $finish;
  end

  // idle cycles before the next beat on either side
  function automatic int pick_gap();
    return steady ? 0 : $urandom_range(0, 6);
  endfunction

  // result side: random stall, then hold ready until one beat is taken
  initial begin : result_sink
    int gap;
    out_ch.ready = 1'b0;
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  // one input beat; valid stays up afterwards so back-to-back beats need no toggle
  task automatic send_beat(input logic [1:0] cmd, input logic [15:0] count,
                           input logic sensor);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.cmd         <= cmd;
    in_ch.step_count  <= count;
    in_ch.home_sensor <= sensor;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  // stop sending and let every outstanding result come back
  task automatic hold_until_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // tick with the sensor high until any run, search or overrun is over
  task automatic settle_motor();
    hold_until_drained();
    while (motor_running) begin
      repeat (8) send_beat(hss_pkg::CMD_TICK, 16'($urandom), 1'b1);
      hold_until_drained();
    end
  endtask

  // both registers, only with the block idle and empty
  task automatic write_config(input logic [15:0] limit, input logic [3:0] overrun);
    settle_motor();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= hss_pkg::CFG_SEARCH_LIMIT;
    cfg_ch.data  <= limit;
    do @(posedge clk); while (!cfg_ch.ready);
    // upper data bits are don't-care for the overrun register
    cfg_ch.index <= hss_pkg::CFG_OVERRUN;
    cfg_ch.data  <= {12'($urandom), overrun};
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    overrun_now = overrun;
    @(posedge clk);
  endtask

  // a start or unused code dropped in during a run or search
  task automatic stray_command();
    logic [1:0] cmd;
    case ($urandom_range(0, 2))
      0: cmd = hss_pkg::CMD_REVERSE;
      1: cmd = hss_pkg::CMD_SEARCH;
      default: cmd = CMD_IGNORED;
    endcase
    // short count: the motor may already be idle when this lands
    send_beat(cmd, 16'($urandom_range(0, 24)), 1'($urandom));
  endtask

  task automatic reverse_run(input int steps);
    int i;
    send_beat(hss_pkg::CMD_REVERSE, 16'(steps), 1'($urandom));
    for (i = 0; i < steps; i++) begin
      if ($urandom_range(0, 11) == 0) begin
        stray_command();
      end
      send_beat(hss_pkg::CMD_TICK, 16'($urandom), 1'($urandom));
    end
  endtask

  // sensor comes up on tick number hit, unless the limit or an earlier random sensor pulse ends
  // the search first; enough ticks follow to cover the overrun and up to two idle ones
  task automatic home_search(input int hit);
    int   i;
    int   total;
    logic sensor;
    send_beat(hss_pkg::CMD_SEARCH, 16'($urandom), 1'($urandom));
    total = hit + overrun_now + $urandom_range(0, 2);
    for (i = 1; i <= total; i++) begin
      if ($urandom_range(0, 11) == 0) begin
        stray_command();
      end
      if (i < hit) begin
        sensor = ($urandom_range(0, 15) == 0);
      end else if (i == hit) begin
        sensor = 1'b1;
      end else begin
        sensor = 1'($urandom);
      end
      send_beat(hss_pkg::CMD_TICK, 16'($urandom), sensor);
    end
  endtask

  // mostly complete runs and searches, some loose beats, random pauses
  task automatic random_phase(input logic [15:0] limit, input logic [3:0] overrun);
    int first;
    int pick;
    write_config(limit, overrun);
    first = items_sent;
    while (items_sent - first < PHASE_ITEMS) begin
      steady = ($urandom_range(0, 4) == 0);
      pick   = $urandom_range(0, 99);
      if (pick < 40) begin
        reverse_run(($urandom_range(0, 19) == 0) ? $urandom_range(25, 200)
                                                 : $urandom_range(0, 24));
      end else if (pick < 85) begin
        home_search($urandom_range(1, 40));
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_beat(2'($urandom), 16'($urandom_range(0, 24)), 1'($urandom));
        end
      end
      // sender waits for the pipeline to empty now and then
      if ($urandom_range(0, 9) == 0) begin
        hold_until_drained();
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.cmd         = hss_pkg::CMD_TICK;
    in_ch.step_count  = 16'd0;
    in_ch.home_sensor = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = hss_pkg::CFG_SEARCH_LIMIT;
    cfg_ch.data       = 16'd0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset config, limit 500 and three overrun steps
    send_beat(hss_pkg::CMD_TICK, 16'hFFFF, 1'b1);     // tick while idle, coils stay off
    send_beat(CMD_IGNORED, 16'hFFFF, 1'b1);           // unused command code
    send_beat(hss_pkg::CMD_REVERSE, 16'h0000, 1'b0);  // zero-step run finishes at once
    send_beat(hss_pkg::CMD_REVERSE, 16'd3, 1'b1);
    send_beat(hss_pkg::CMD_SEARCH, 16'hFFFF, 1'b1);   // start while busy is dropped
    send_beat(hss_pkg::CMD_TICK, 16'h0000, 1'b1);     // sensor means nothing in reverse
    send_beat(hss_pkg::CMD_REVERSE, 16'hFFFF, 1'b0);  // dropped as well
    send_beat(hss_pkg::CMD_TICK, 16'h0000, 1'b0);
    send_beat(hss_pkg::CMD_TICK, 16'h0000, 1'b0);     // run done
    send_beat(hss_pkg::CMD_SEARCH, 16'h0000, 1'b1);   // sensor not sampled on a start
    send_beat(hss_pkg::CMD_TICK, 16'h0000, 1'b1);     // home on the first step, overrun
    send_beat(hss_pkg::CMD_REVERSE, 16'd5, 1'b0);     // dropped during overrun
    repeat (3) send_beat(hss_pkg::CMD_TICK, 16'h0000, 1'b0);
    send_beat(hss_pkg::CMD_TICK, 16'h0000, 1'b0);     // idle again, coils hold

    // limit of zero behaves as one, no overrun: search ends on its only step
    write_config(16'd0, 4'd0);
    send_beat(hss_pkg::CMD_SEARCH, 16'h0000, 1'b0);
    send_beat(hss_pkg::CMD_TICK, 16'h0000, 1'b0);
    // limit of two reached with the sensor low
    write_config(16'd2, 4'd0);
    send_beat(hss_pkg::CMD_SEARCH, 16'h0000, 1'b0);
    send_beat(hss_pkg::CMD_TICK, 16'h0000, 1'b0);
    send_beat(hss_pkg::CMD_TICK, 16'h0000, 1'b0);

    // random phases across register settings, extremes included
    random_phase(16'd1, 4'd0);
    random_phase(16'd0, 4'd15);
    random_phase(16'd7, 4'd1);
    random_phase(16'hFFFF, 4'd15);
    random_phase(16'($urandom_range(2, 40)), 4'($urandom));
    random_phase(hss_pkg::SEARCH_LIMIT_RST, hss_pkg::OVERRUN_RST);

    // a long reverse run at full rate
    settle_motor();
    steady = 1'b1;
    reverse_run(120);
    steady = 1'b0;

    hold_until_drained();
    if (error_count == 0 && results_owed == 0) begin
      $display("PASS stepper_half_step_homing_sequencer_unit");
    end else begin
      $display("FAIL stepper_half_step_homing_sequencer_unit");
    end
    $finish;
  end

endmodule
